/* design/cpfm_pkg.sv */
// cpfm_pkg: shared widths, constants and types of the capture pair frequency meter
// used by every module of the block; no dependencies
`default_nettype none

package cpfm_pkg;

    // field and register widths
    localparam int TIMER_BITS = 16;
    localparam int FREQ_W     = 25;
    localparam int SHIFT_W    = 3;
    localparam int CFG_IDX_W  = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_SHIFT = 1'b1;

    // register reset values
    localparam logic [FREQ_W-1:0]  TICK_RATE_RST  = FREQ_W'(1000000);
    localparam logic [SHIFT_W-1:0] EDGE_SHIFT_RST = SHIFT_W'(4);

    // period queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // divider step counter
    localparam int DIV_CNT_W = $clog2(FREQ_W);

    // one measurement waiting for the divider
    typedef struct packed {
        logic [TIMER_BITS-1:0] period;
        logic [FREQ_W-1:0]     tick_rate;
    } t_meas;

endpackage

`default_nettype wire

/* design/capture_pair_frequency_meter.sv */
// capture_pair_frequency_meter: top level, configuration registers, front, queue and divider
// depends on cpfm_pkg, cpfm_front, cpfm_queue, cpfm_back
`default_nettype none

// Reciprocal frequency meter fed with free-running timer captures. Capture words are taken in
// pairs: the first is stored and gives no result, the second yields one result word holding
// tick_rate_hz / ((second - first) mod 2^16 >> edge_shift), truncated, with status 1 and a
// frequency of 0 when that period is zero. The first capture of a pair is always taken; the
// second goes to a two-entry queue and is taken whenever that queue has room. The bit-serial
// divider sets the throughput: it loads a pair, forms the quotient bits in turn and hands the
// word to the output register, skipping the bits for a zero period. The result register frees
// the divider as soon as a word is loaded, so a stalled output holds back at most one word.
// Register writes take effect at once; for a pair the values in force at its second capture count.

module capture_pair_frequency_meter import cpfm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [FREQ_W-1:0]     i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [TIMER_BITS-1:0] i_capture_value,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [FREQ_W-1:0]          o_frequency_hz,
    output logic                       o_status
);

    logic [FREQ_W-1:0]  r_tick_rate;
    logic [SHIFT_W-1:0] r_edge_shift;

    logic  push;
    logic  q_ready;
    logic  q_valid;
    logic  pop;
    t_meas push_data;
    t_meas pop_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate  <= TICK_RATE_RST;
            r_edge_shift <= EDGE_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TICK_RATE:  r_tick_rate  <= i_cfg_data;
                REG_EDGE_SHIFT: r_edge_shift <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // capture pairing
    cpfm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_capture_value (i_capture_value),
        .i_tick_rate     (r_tick_rate),
        .i_edge_shift    (r_edge_shift),
        .o_push          (push),
        .o_meas          (push_data),
        .i_q_ready       (q_ready)
    );

    // decoupling queue
    cpfm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (pop_data)
    );

    // division and result word
    cpfm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (pop_data),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frequency_hz (o_frequency_hz),
        .o_status       (o_status)
    );

    // checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_ready)
        else $error("period queue written while full");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_frequency_hz == '0)
        else $error("zero period word carries a nonzero frequency");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !q_valid)
        else $error("result or queue valid right after reset");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("divider took a word from an empty queue");

endmodule

`default_nettype wire

/* design/cpfm_front.sv */
// cpfm_front: pairs incoming capture words and forms the period in ticks
// depends on cpfm_pkg
`default_nettype none

module cpfm_front import cpfm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [TIMER_BITS-1:0] i_capture_value,
    input  wire logic [FREQ_W-1:0]     i_tick_rate,
    input  wire logic [SHIFT_W-1:0]    i_edge_shift,
    output logic                       o_push,
    output t_meas                      o_meas,
    input  wire logic                  i_q_ready
);

    logic                  r_have_first;
    logic [TIMER_BITS-1:0] r_first;
    logic                  n_have_first;
    logic                  accept;
    logic [TIMER_BITS-1:0] diff;

    // a first capture is always taken; a second one needs queue space
    assign o_ready = !r_have_first || i_q_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && r_have_first;

    // wrap-safe span over the edge group, then one period
    assign diff             = i_capture_value - r_first;
    assign o_meas.period    = diff >> i_edge_shift;
    assign o_meas.tick_rate = i_tick_rate;

    // pair tracking
    always_comb begin
        n_have_first = r_have_first;
        if (accept) begin
            n_have_first = !r_have_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
        end else begin
            r_have_first <= n_have_first;
        end
        if (accept && !r_have_first) begin
            r_first <= i_capture_value;
        end
    end

endmodule

`default_nettype wire

/* design/cpfm_queue.sv */
// cpfm_queue: short first-in first-out queue of measurements
// depends on cpfm_pkg
`default_nettype none

module cpfm_queue import cpfm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_meas      i_data,
    output logic       o_ready,
    output logic       o_valid,
    input  wire logic  i_pop,
    output t_meas      o_data
);

    t_meas              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_ready = r_count != Q_CNT_W'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/cpfm_back.sv */
// cpfm_back: bit-serial restoring divider, tick rate over period, plus output word register
// depends on cpfm_pkg
`default_nettype none

module cpfm_back import cpfm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  t_meas                   i_q_data,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [FREQ_W-1:0]       o_frequency_hz,
    output logic                    o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [TIMER_BITS:0]   r_rem;
    logic [FREQ_W-1:0]     r_quo;
    logic [TIMER_BITS-1:0] r_div;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_err;
    logic                  r_out_valid;
    logic [FREQ_W-1:0]     r_out_freq;
    logic                  r_out_status;

    logic [TIMER_BITS:0]   trial;
    logic                  fits;
    logic                  out_free;

    assign o_pop          = (r_state == S_IDLE) && i_q_valid;
    assign o_valid        = r_out_valid;
    assign o_frequency_hz = r_out_freq;
    assign o_status       = r_out_status;
    assign out_free       = !r_out_valid || i_ready;

    // one quotient bit per cycle
    assign trial = {r_rem[TIMER_BITS-1:0], r_quo[FREQ_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    // divider sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // result word: loaded from the divider or emptied by the receiver
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_freq   <= r_quo;
                r_out_status <= r_err;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_rem <= '0;
                        r_div <= i_q_data.period;
                        r_cnt <= '0;
                        if (i_q_data.period == '0) begin
                            r_quo   <= '0;
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_quo   <= i_q_data.tick_rate;
                            r_err   <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= fits ? trial - {1'b0, r_div} : trial;
                    r_quo <= {r_quo[FREQ_W-2:0], fits};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(FREQ_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
